// ===== rtl/yrc_pkg.sv =====
package yrc_pkg;

   // field widths
   localparam int SampleW    = 8;
   localparam int SizeW      = 13;
   localparam int RowW       = 12;
   localparam int CsrIndexW  = 2;
   localparam int LimW       = 14;   // holds any width limit up to 8192
   localparam int PairW      = 2 * SampleW;

   localparam int DefMaxWidth = 4096;
   localparam int MaxHeight   = 4096;

   // register indexes
   localparam logic [CsrIndexW-1:0] CsrFrameWidth  = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrFrameHeight = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrChromaSwap  = 2'd2;

   localparam logic [SizeW-1:0] ResetWidth  = 13'd640;
   localparam logic [SizeW-1:0] ResetHeight = 13'd480;

   // BT.601 full range, scaled by 256
   localparam logic signed [17:0] CoefUB    = 18'sd454;
   localparam logic signed [17:0] CoefUG    = 18'sd88;
   localparam logic signed [17:0] CoefVG    = 18'sd183;
   localparam logic signed [17:0] CoefVR    = 18'sd359;
   localparam logic signed [8:0]  ChromaMid = 9'sd128;

   localparam logic [SampleW-1:0] SampleMax   = 8'hFF;
   localparam logic [SampleW-1:0] AlphaOpaque = 8'd255;

endpackage

// ===== rtl/yrc_req_if.sv =====
interface yrc_req_if;
   logic                          valid;
   logic                          ready;
   logic [yrc_pkg::SampleW-1:0]   luma;
   logic [yrc_pkg::SampleW-1:0]   chroma_first;
   logic [yrc_pkg::SampleW-1:0]   chroma_second;

   modport source (output valid, output luma, output chroma_first, output chroma_second,
                   input ready);
   modport sink   (input valid, input luma, input chroma_first, input chroma_second,
                   output ready);
endinterface

// ===== rtl/yrc_rsp_if.sv =====
interface yrc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [yrc_pkg::SampleW-1:0]   blue;
   logic [yrc_pkg::SampleW-1:0]   green;
   logic [yrc_pkg::SampleW-1:0]   red;
   logic [yrc_pkg::SampleW-1:0]   alpha;
   logic                          end_of_line;
   logic                          end_of_frame;

   modport source (output valid, output blue, output green, output red, output alpha,
                   output end_of_line, output end_of_frame, input ready);
   modport sink   (input valid, input blue, input green, input red, input alpha,
                   input end_of_line, input end_of_frame, output ready);
endinterface

// ===== rtl/yuv420_to_rgb32_converter.sv =====
// Channel   Direction  Payload
// req_chan  in         luma, chroma_first, chroma_second
// rsp_chan  out        blue, green, red, alpha, end_of_line, end_of_frame
// csr_*     in         frame_width (0), frame_height (1), chroma_swap (2)
//
// One pixel per clock sustained while rsp_chan.ready holds; a pixel is registered in stage one
// and then in stage two before rsp valid rises.
// Stage one registers the pixel, the raster position and the chroma line store read;
// stage two registers the clamped colours.
// Reset (synchronous) clears counters, stage valids and the registers to their defaults.
// The line store has no reset; odd rows read what the even row above wrote.
// A stalled rsp fills stage one, then req_chan.ready drops until rsp moves.
module yuv420_to_rgb32_converter #(
   parameter int MAX_WIDTH = yrc_pkg::DefMaxWidth
) (
   input  logic                            clock,
   input  logic                            reset,
   yrc_req_if.sink                         req_chan,
   yrc_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [yrc_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [yrc_pkg::SizeW-1:0]       csr_write_data
);

   localparam int LimW  = yrc_pkg::LimW;
   localparam int ColW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int Depth = MAX_WIDTH / 2;
   localparam int SlotW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int RowW  = yrc_pkg::RowW;
   localparam int SW    = yrc_pkg::SampleW;
   localparam int PW    = yrc_pkg::PairW;

   // configuration
   logic [yrc_pkg::SizeW-1:0] frame_width_ff;
   logic [yrc_pkg::SizeW-1:0] frame_height_ff;
   logic                      chroma_swap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= yrc_pkg::ResetWidth;
         frame_height_ff <= yrc_pkg::ResetHeight;
         chroma_swap_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            yrc_pkg::CsrFrameWidth:  frame_width_ff  <= csr_write_data;
            yrc_pkg::CsrFrameHeight: frame_height_ff <= csr_write_data;
            yrc_pkg::CsrChromaSwap:  chroma_swap_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // handshake
   logic a_valid_ff;
   logic b_valid_ff;
   logic a_advance;
   logic req_xfer;

   assign a_advance      = a_valid_ff && (!b_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !a_valid_ff || a_advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   // raster position
   logic [ColW-1:0] col_cnt_ff, col_cnt_in;
   logic [RowW-1:0] row_cnt_ff, row_cnt_in;
   logic [LimW-1:0] width_m1;
   logic [yrc_pkg::SizeW-1:0] height_m1;
   logic [LimW-1:0] col_ext;
   logic [LimW-1:0] slot_full;
   logic [SlotW-1:0] slot;
   logic eol, eof, chroma_pixel;

   always_comb begin
      if (frame_width_ff == '0)
         width_m1 = '0;
      else if (LimW'(frame_width_ff) > LimW'(MAX_WIDTH))
         width_m1 = LimW'(MAX_WIDTH - 1);
      else
         width_m1 = LimW'(frame_width_ff) - LimW'(1);

      if (frame_height_ff == '0)
         height_m1 = '0;
      else if (frame_height_ff > yrc_pkg::SizeW'(yrc_pkg::MaxHeight))
         height_m1 = yrc_pkg::SizeW'(yrc_pkg::MaxHeight - 1);
      else
         height_m1 = frame_height_ff - 1'b1;

      col_ext = LimW'(col_cnt_ff);
      eol     = col_ext >= width_m1;
      eof     = eol && ({1'b0, row_cnt_ff} >= height_m1);

      // an odd MAX_WIDTH leaves one column pair past the store; it wraps to slot zero
      slot_full = col_ext >> 1;
      if (slot_full >= LimW'(Depth))
         slot_full = slot_full - LimW'(Depth);
      slot = slot_full[SlotW-1:0];

      chroma_pixel = !row_cnt_ff[0] && !col_cnt_ff[0];

      if (eol) begin
         col_cnt_in = '0;
         row_cnt_in = eof ? '0 : row_cnt_ff + 1'b1;
      end else begin
         col_cnt_in = col_cnt_ff + 1'b1;
         row_cnt_in = row_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (req_xfer) begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   // chroma line store
   logic [PW-1:0] chroma_line [Depth];
   logic [PW-1:0] line_rd_ff;
   logic [PW-1:0] last_pair_ff;
   logic [PW-1:0] in_pair;

   assign in_pair = {req_chan.chroma_first, req_chan.chroma_second};

   always_ff @(posedge clock) begin
      if (req_xfer && chroma_pixel)
         chroma_line[slot] <= in_pair;
      if (req_xfer)
         line_rd_ff <= chroma_line[slot];
   end

   always_ff @(posedge clock) begin
      if (req_xfer && chroma_pixel)
         last_pair_ff <= in_pair;
   end

   // stage one
   logic [SW-1:0] a_luma_ff;
   logic [PW-1:0] a_pair_ff;
   logic          a_use_line_ff;
   logic          a_eol_ff, a_eof_ff;

   always_ff @(posedge clock) begin
      if (reset)
         a_valid_ff <= 1'b0;
      else if (req_chan.ready)
         a_valid_ff <= req_chan.valid;
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         a_luma_ff     <= req_chan.luma;
         // even row: own pair, or the one just stored at the even column before
         a_pair_ff     <= chroma_pixel ? in_pair : last_pair_ff;
         a_use_line_ff <= row_cnt_ff[0];
         a_eol_ff      <= eol;
         a_eof_ff      <= eof;
      end
   end

   // colour maths
   logic [PW-1:0]        pair;
   logic [SW-1:0]        u_byte, v_byte;
   logic signed [8:0]    u_off, v_off;
   logic signed [17:0]   prod_b, prod_g, prod_r;
   logic signed [10:0]   sum_b, sum_g, sum_r;
   logic [SW-1:0]        blue_in, green_in, red_in;

   function automatic logic [SW-1:0] clamp_byte(input logic signed [10:0] v);
      logic [SW-1:0] res;
      if (v < 0)
         res = '0;
      else if (v > 11'sd255)
         res = yrc_pkg::SampleMax;
      else
         res = v[SW-1:0];
      return res;
   endfunction

   always_comb begin
      pair   = a_use_line_ff ? line_rd_ff : a_pair_ff;
      u_byte = chroma_swap_ff ? pair[SW-1:0] : pair[PW-1:SW];
      v_byte = chroma_swap_ff ? pair[PW-1:SW] : pair[SW-1:0];
      u_off  = $signed({1'b0, u_byte}) - yrc_pkg::ChromaMid;
      v_off  = $signed({1'b0, v_byte}) - yrc_pkg::ChromaMid;

      prod_b = 18'(u_off) * yrc_pkg::CoefUB;
      prod_g = 18'(u_off) * yrc_pkg::CoefUG + 18'(v_off) * yrc_pkg::CoefVG;
      prod_r = 18'(v_off) * yrc_pkg::CoefVR;

      // floor division by 256: keep the top bits of the signed product
      sum_b = $signed({3'b000, a_luma_ff}) + 11'($signed(prod_b[17:8]));
      sum_g = $signed({3'b000, a_luma_ff}) - 11'($signed(prod_g[17:8]));
      sum_r = $signed({3'b000, a_luma_ff}) + 11'($signed(prod_r[17:8]));

      blue_in  = clamp_byte(sum_b);
      green_in = clamp_byte(sum_g);
      red_in   = clamp_byte(sum_r);
   end

   // stage two
   logic [SW-1:0] b_blue_ff, b_green_ff, b_red_ff;
   logic          b_eol_ff, b_eof_ff;

   always_ff @(posedge clock) begin
      if (reset)
         b_valid_ff <= 1'b0;
      else if (!b_valid_ff || rsp_chan.ready)
         b_valid_ff <= a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (a_advance) begin
         b_blue_ff  <= blue_in;
         b_green_ff <= green_in;
         b_red_ff   <= red_in;
         b_eol_ff   <= a_eol_ff;
         b_eof_ff   <= a_eof_ff;
      end
   end

   assign rsp_chan.valid        = b_valid_ff;
   assign rsp_chan.blue         = b_blue_ff;
   assign rsp_chan.green        = b_green_ff;
   assign rsp_chan.red          = b_red_ff;
   assign rsp_chan.alpha        = yrc_pkg::AlphaOpaque;
   assign rsp_chan.end_of_line  = b_eol_ff;
   assign rsp_chan.end_of_frame = b_eof_ff;

`ifndef SYNTH
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      LimW'(col_cnt_ff) <= LimW'(MAX_WIDTH - 1))
      else $error("column count beyond line limit");

   a_col_steps: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !eol) |=> (col_cnt_ff == ColW'($past(col_cnt_ff) + 1'b1)))
      else $error("column count did not step by one");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && b_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("transfer taken with both stages full and rsp stalled");

   a_eof_on_eol: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (!b_eof_ff || b_eol_ff))
      else $error("frame end without line end");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!a_valid_ff && !b_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule
